@@ sv/line_rasterizer_defines.svh @@
// Assertion macros shared by the rasterizer RTL.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define LR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lr_pkg.sv @@
`default_nettype none

package lr_pkg;

	// Width of every pixel coordinate.
	localparam int COORD_BITS = 12;
	localparam int COLOR_BITS = 32;
	// Signed doubled error term needs three bits beyond a coordinate.
	localparam int ERR_BITS = COORD_BITS + 3;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                  command;
		logic [COORD_BITS-1:0] x_start;
		logic [COORD_BITS-1:0] y_start;
		logic [COORD_BITS-1:0] x_end;
		logic [COORD_BITS-1:0] y_end;
		logic [COLOR_BITS-1:0] line_color;
	} cmd_item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [COLOR_BITS-1:0] pixel_color;
		logic                  last;
	} pix_item_t;

endpackage

`default_nettype wire

@@ sv/line_rasterizer.sv @@
`default_nettype none

// Bresenham line rasterizer. A start command carries two endpoints and a
// color and produces the first pixel of the line at once; every step command
// after it produces the next pixel, and the final pixel carries last. A step
// with no line in progress produces no pixel, and a start always abandons the
// line in progress. Both ports take one transfer per cycle: a command is
// latched in an input register, the setup, the pixel select and the error
// update are done in a single pass of logic, and the pixel lands in an output
// register. The sustained rate, while the pixel port does not stall, is one
// command and one pixel per cycle; it is set by the loop through the line
// state (error term and minor coordinate), which every command reads and
// writes. A stall on the pixel port holds the output register and, in the
// same cycle, stalls the command port once the input register is full.

`include "line_rasterizer_defines.svh"

module line_rasterizer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire lr_pkg::cmd_item_t cmd_data,
	output logic                   pix_valid,
	input  wire logic              pix_stall,
	output lr_pkg::pix_item_t      pix_data
);

	localparam int N  = lr_pkg::COORD_BITS;
	localparam int EW = lr_pkg::ERR_BITS;

	// Input register.
	lr_pkg::cmd_item_t s1_q;
	logic              s1_valid_q;

	// Line state.
	logic                           active_q;
	logic                           steep_q;
	logic [N-1:0]                   major_pos_q;
	logic [N-1:0]                   minor_pos_q;
	logic [N-1:0]                   major_end_q;
	logic [N-1:0]                   major_delta_q;
	logic [N:0]                     twice_minor_delta_q;
	logic signed [EW-1:0]           error_q;
	logic                           minor_down_q;
	logic [lr_pkg::COLOR_BITS-1:0]  held_color_q;

	// Output register.
	lr_pkg::pix_item_t pix_q;
	logic              pix_valid_q;

	logic fire;
	logic is_start;
	logic emit;

	// Setup of a new line from the latched endpoints.
	logic [N-1:0] dx, dy;
	logic         su_steep;
	logic [N-1:0] a0, b0, a1, b1;
	logic         su_swap;
	logic [N-1:0] su_major, su_minor, su_end, su_minor_end;
	logic [N-1:0] su_delta, su_minor_diff;
	logic         su_down;

	// Values the current pixel is taken from.
	logic                          cur_steep;
	logic [N-1:0]                  cur_major, cur_minor, cur_end, cur_delta;
	logic [N:0]                    cur_tmd;
	logic signed [EW-1:0]          cur_err;
	logic                          cur_down;
	logic [lr_pkg::COLOR_BITS-1:0] cur_color;
	logic                          cur_last;

	logic signed [EW-1:0] err_sum;
	logic signed [EW-1:0] delta_ext;
	logic signed [EW-1:0] err_next;
	logic                 minor_move;
	logic [N-1:0]         minor_next;

	// The pass fires when an item waits and the output register can take it.
	assign fire      = s1_valid_q && (!pix_valid_q || !pix_stall);
	assign cmd_stall = s1_valid_q && !fire;
	assign is_start  = (s1_q.command == lr_pkg::CMD_START);
	assign emit      = is_start || active_q;

	always_comb begin
		dx = (s1_q.x_end >= s1_q.x_start) ? s1_q.x_end - s1_q.x_start
		                                   : s1_q.x_start - s1_q.x_end;
		dy = (s1_q.y_end >= s1_q.y_start) ? s1_q.y_end - s1_q.y_start
		                                   : s1_q.y_start - s1_q.y_end;
		// A steep line walks along y, so the axes trade places.
		su_steep = (dx < dy);
		a0 = su_steep ? s1_q.y_start : s1_q.x_start;
		b0 = su_steep ? s1_q.x_start : s1_q.y_start;
		a1 = su_steep ? s1_q.y_end   : s1_q.x_end;
		b1 = su_steep ? s1_q.x_end   : s1_q.y_end;
		// Order the endpoints so the major coordinate rises.
		su_swap      = (a1 < a0);
		su_major     = su_swap ? a1 : a0;
		su_minor     = su_swap ? b1 : b0;
		su_end       = su_swap ? a0 : a1;
		su_minor_end = su_swap ? b0 : b1;
		su_delta     = su_end - su_major;
		su_minor_diff = (su_minor_end >= su_minor) ? su_minor_end - su_minor
		                                           : su_minor - su_minor_end;
		su_down = (su_minor_end <= su_minor);
	end

	always_comb begin
		if (is_start) begin
			cur_steep = su_steep;
			cur_major = su_major;
			cur_minor = su_minor;
			cur_end   = su_end;
			cur_delta = su_delta;
			cur_tmd   = {su_minor_diff, 1'b0};
			cur_err   = '0;
			cur_down  = su_down;
			cur_color = s1_q.line_color;
		end else begin
			cur_steep = steep_q;
			cur_major = major_pos_q;
			cur_minor = minor_pos_q;
			cur_end   = major_end_q;
			cur_delta = major_delta_q;
			cur_tmd   = twice_minor_delta_q;
			cur_err   = error_q;
			cur_down  = minor_down_q;
			cur_color = held_color_q;
		end
		cur_last = (cur_major == cur_end);

		err_sum    = cur_err + $signed({2'b00, cur_tmd});
		delta_ext  = $signed({3'b000, cur_delta});
		minor_move = (err_sum > delta_ext);
		err_next   = minor_move ? err_sum - $signed({2'b00, cur_delta, 1'b0}) : err_sum;
		minor_next = cur_down ? cur_minor - 1'b1 : cur_minor + 1'b1;
	end

	// Input register: it takes a transfer whenever it is empty or drains now.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!cmd_stall) begin
			s1_valid_q <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			s1_q <= cmd_data;
		end
	end

	// Line state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pix_valid_q <= 1'b0;
		end else if (fire) begin
			pix_valid_q <= emit;
			if (emit) begin
				active_q <= !cur_last;
			end
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			pix_q.pixel_x     <= cur_steep ? cur_minor : cur_major;
			pix_q.pixel_y     <= cur_steep ? cur_major : cur_minor;
			pix_q.pixel_color <= cur_color;
			pix_q.last        <= cur_last;

			steep_q             <= cur_steep;
			major_end_q         <= cur_end;
			major_delta_q       <= cur_delta;
			twice_minor_delta_q <= cur_tmd;
			minor_down_q        <= cur_down;
			held_color_q        <= cur_color;
			if (cur_last) begin
				major_pos_q <= cur_major;
				minor_pos_q <= cur_minor;
				error_q     <= cur_err;
			end else begin
				major_pos_q <= cur_major + 1'b1;
				minor_pos_q <= minor_move ? minor_next : cur_minor;
				error_q     <= err_next;
			end
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix_data  = pix_q;

	`LR_ASSERT_NOW(a_full_stall, s1_valid_q && pix_valid_q && pix_stall, cmd_stall, "command taken while output blocked")
	`LR_ASSERT_NEXT(a_last_idle, fire && emit && cur_last, !active_q, "line still active after last pixel")
	`LR_ASSERT_NOW(a_major_range, active_q, major_pos_q <= major_end_q, "major position beyond line end")
	`LR_ASSERT_NEXT(a_idle_step, fire && !emit, !pix_valid_q, "pixel produced by a step with no line")

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the Bresenham line rasterizer.
//
// Commands are queued by the stimulus process and presented by a clocked
// driver. A clocked monitor takes the pixels and compares them with the
// pixels that the line tracker below has worked out. The tracker follows
// every accepted command transfer with its own copy of the line state, so
// the expected pixel stream is always known ahead of the block.
module tb;

	localparam int COORD_W     = lr_pkg::COORD_BITS;
	localparam int COORD_MAX   = (1 << COORD_W) - 1;
	// Cycles without any transfer before the run is declared hung. This is far
	// longer than the longest idle that a correct run draws on either side.
	localparam int QUIET_LIMIT = 2000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	lr_pkg::cmd_item_t cmd_data  = '0;
	logic              pix_valid;
	logic              pix_stall = 1'b0;
	lr_pkg::pix_item_t pix_data;

	line_rasterizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data)
	);

	initial forever #1 clk = ~clk;

	// Commands waiting for the driver, and pixels waiting for the monitor.
	lr_pkg::cmd_item_t pending_cmds[$];
	lr_pkg::pix_item_t pixels_due[$];

	int fault_count  = 0;
	int quiet_cycles = 0;
	int cmd_wait     = 0;
	int stall_left   = 0;
	// Idle styles: 0 never idles, 1 draws a random idle on every transfer,
	// 2 idles only now and then. Each side has its own style.
	int drv_mode     = 1;
	int mon_mode     = 1;

	// Line tracker state, mirroring the rasterizer's line registers.
	logic                              ln_active = 1'b0;
	logic                              ln_steep  = 1'b0;
	logic [COORD_W-1:0]                maj_pos   = '0;
	logic [COORD_W-1:0]                min_pos   = '0;
	logic [COORD_W-1:0]                maj_end   = '0;
	logic [COORD_W-1:0]                maj_delta = '0;
	logic [COORD_W:0]                  min_twice = '0;
	logic signed [lr_pkg::ERR_BITS-1:0] err_acc  = '0;
	logic                              min_down  = 1'b0;
	logic [lr_pkg::COLOR_BITS-1:0]     ln_color  = '0;

	function automatic int idle_draw(input int mode);
		if (mode == 0)
			return 0;
		if (mode == 2 && $urandom_range(0, 7) != 0)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		fault_count++;
	endtask

	// Follows one accepted command. A start sets up the line (swapping axes
	// for a steep line and ordering the ends so the major coordinate rises)
	// and emits its first pixel; a step emits the next pixel, or nothing when
	// no line is in progress.
	function automatic void trace_pixel(input lr_pkg::cmd_item_t c);
		logic [COORD_W-1:0] a0, b0, a1, b1, t, da, db;
		lr_pkg::pix_item_t p;
		if (c.command == lr_pkg::CMD_START) begin
			a0 = c.x_start;
			b0 = c.y_start;
			a1 = c.x_end;
			b1 = c.y_end;
			da = (a1 > a0) ? a1 - a0 : a0 - a1;
			db = (b1 > b0) ? b1 - b0 : b0 - b1;
			ln_steep = (da < db);
			if (ln_steep) begin
				t = a0; a0 = b0; b0 = t;
				t = a1; a1 = b1; b1 = t;
			end
			if (a1 < a0) begin
				t = a0; a0 = a1; a1 = t;
				t = b0; b0 = b1; b1 = t;
			end
			maj_pos   = a0;
			min_pos   = b0;
			maj_end   = a1;
			maj_delta = a1 - a0;
			min_twice = {((b1 > b0) ? b1 - b0 : b0 - b1), 1'b0};
			err_acc   = '0;
			min_down  = (b1 <= b0);
			ln_color  = c.line_color;
			ln_active = 1'b1;
		end else if (!ln_active) begin
			return;
		end
		p.pixel_x     = ln_steep ? min_pos : maj_pos;
		p.pixel_y     = ln_steep ? maj_pos : min_pos;
		p.pixel_color = ln_color;
		p.last        = (maj_pos == maj_end);
		pixels_due.push_back(p);
		if (p.last) begin
			ln_active = 1'b0;
		end else begin
			err_acc = err_acc + $signed({2'b00, min_twice});
			if (err_acc > $signed({3'b000, maj_delta})) begin
				err_acc = err_acc - $signed({2'b00, maj_delta, 1'b0});
				min_pos = min_down ? min_pos - 1'b1 : min_pos + 1'b1;
			end
			maj_pos = maj_pos + 1'b1;
		end
	endfunction

	function automatic void queue_start(input int x0, input int y0, input int x1,
			input int y1, input logic [lr_pkg::COLOR_BITS-1:0] color);
		lr_pkg::cmd_item_t c;
		c.command    = lr_pkg::CMD_START;
		c.x_start    = COORD_W'(x0);
		c.y_start    = COORD_W'(y0);
		c.x_end      = COORD_W'(x1);
		c.y_end      = COORD_W'(y1);
		c.line_color = color;
		pending_cmds.push_back(c);
	endfunction

	// Step commands carry random junk in the endpoint and color fields, which
	// the block must ignore.
	function automatic void queue_steps(input int count);
		lr_pkg::cmd_item_t c;
		for (int i = 0; i < count; i++) begin
			c.command    = lr_pkg::CMD_STEP;
			c.x_start    = COORD_W'($urandom);
			c.y_start    = COORD_W'($urandom);
			c.x_end      = COORD_W'($urandom);
			c.y_end      = COORD_W'($urandom);
			c.line_color = $urandom;
			pending_cmds.push_back(c);
		end
	endfunction

	// Queues one random sequence and returns how many commands it holds.
	// Most sequences are a start followed by exactly enough steps to finish
	// the line; some are cut short by the next start, some run past the end
	// with steps that must produce nothing, and some are lone random commands.
	function automatic int queue_line();
		int kind, reach, x0, y0, x1, y1, len, steps, pick;
		lr_pkg::cmd_item_t c;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			c.command    = lr_pkg::cmd_t'($urandom_range(0, 1));
			c.x_start    = COORD_W'($urandom);
			c.y_start    = COORD_W'($urandom);
			c.x_end      = COORD_W'($urandom);
			c.y_end      = COORD_W'($urandom);
			c.line_color = $urandom;
			pending_cmds.push_back(c);
			return 1;
		end
		reach = (kind < 15) ? COORD_MAX : ((kind < 40) ? 40 : 12);
		x0 = $urandom_range(0, COORD_MAX);
		y0 = $urandom_range(0, COORD_MAX);
		x1 = $urandom_range((x0 > reach) ? x0 - reach : 0,
			(x0 + reach > COORD_MAX) ? COORD_MAX : x0 + reach);
		y1 = $urandom_range((y0 > reach) ? y0 - reach : 0,
			(y0 + reach > COORD_MAX) ? COORD_MAX : y0 + reach);
		len = (x1 > x0) ? x1 - x0 : x0 - x1;
		if (((y1 > y0) ? y1 - y0 : y0 - y1) > len)
			len = (y1 > y0) ? y1 - y0 : y0 - y1;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			steps = $urandom_range(0, len);
		else if (pick == 1)
			steps = len + $urandom_range(1, 3);
		else
			steps = len;
		// Long lines are mostly abandoned early to keep the run short.
		if (steps > 60)
			steps = $urandom_range(0, 60);
		queue_start(x0, y0, x1, y1, $urandom);
		queue_steps(steps);
		return steps + 1;
	endfunction

	// Blocks until every queued command has gone and every pixel has arrived.
	task automatic wait_drain();
		while (pending_cmds.size() != 0 || cmd_valid || pixels_due.size() != 0)
			@(negedge clk);
	endtask

	// Driver: presents the next queued command, holds it while stalled, and
	// idles for the drawn number of cycles after each transfer. The expected
	// pixels are worked out at the edge where the transfer happens.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				trace_pixel(cmd_data);
			if (!cmd_valid || !cmd_stall) begin
				if (cmd_wait != 0) begin
					cmd_valid <= 1'b0;
					cmd_wait  <= cmd_wait - 1;
				end else if (pending_cmds.size() != 0) begin
					cmd_valid <= 1'b1;
					cmd_data  <= pending_cmds.pop_front();
					cmd_wait  <= idle_draw(drv_mode);
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each pixel transfer against the oldest expected pixel,
	// then stalls the pixel port for the drawn number of cycles.
	always @(posedge clk) begin : pixel_monitor
		int pick;
		lr_pkg::pix_item_t want;
		if (arst_n) begin
			if (pix_valid && !pix_stall) begin
				if (pixels_due.size() == 0) begin
					note_mismatch("pixel with none expected", 32'(pix_data.pixel_x), '0);
				end else begin
					want = pixels_due.pop_front();
					if (pix_data.pixel_x !== want.pixel_x)
						note_mismatch("pixel_x", 32'(pix_data.pixel_x),
							32'(want.pixel_x));
					if (pix_data.pixel_y !== want.pixel_y)
						note_mismatch("pixel_y", 32'(pix_data.pixel_y),
							32'(want.pixel_y));
					if (pix_data.pixel_color !== want.pixel_color)
						note_mismatch("pixel_color", pix_data.pixel_color,
							want.pixel_color);
					if (pix_data.last !== want.last)
						note_mismatch("last", 32'(pix_data.last), 32'(want.last));
				end
				pick = idle_draw(mon_mode);
				pix_stall  <= (pick != 0);
				stall_left <= (pick != 0) ? pick - 1 : 0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
			end else begin
				pix_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a run that stops moving counts as a failure.
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int made;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. A step right after reset must produce nothing, as
		// must a step after a single-point line, which finishes at once.
		queue_steps(1);
		queue_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '1);
		queue_steps(1);
		// Flat horizontal line from the origin, run to its end and one past.
		queue_start(0, 0, 5, 0, '0);
		queue_steps(6);
		// Steep vertical line given top to bottom, so the ends get swapped.
		queue_start(10, 20, 10, 15, 32'h5a5a_a5a5);
		queue_steps(5);
		// Minor coordinate falling, abandoned after one step by a new start.
		queue_start(0, 5, 6, 2, $urandom);
		queue_steps(1);
		// Full-range diagonals, each replacing the line in progress; the
		// second is left running into the random part.
		queue_start(0, 0, COORD_MAX, COORD_MAX, '0);
		queue_steps(2);
		queue_start(COORD_MAX, 0, 0, COORD_MAX, '1);
		queue_steps(2);
		wait_drain();

		// Random part in rounds. Between rounds the commands hold off until
		// every pixel is in, and each side picks a new idle style.
		for (int round = 0; round < 6; round++) begin
			drv_mode = (round == 0) ? 0 : $urandom_range(0, 2);
			mon_mode = (round == 1) ? 0 : $urandom_range(0, 2);
			made = 0;
			while (made < 320)
				made += queue_line();
			wait_drain();
		end

		// Leave time for any stray pixel to show up before the verdict.
		repeat (8) @(negedge clk);
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
